/* hw/rtl/puag_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// puag_pkg
// Shared widths, codes and the CORDIC arctangent table of the panorama
// unwrap address generator.
// ----------------------------------------------------------------------------
package puag_pkg;

	localparam int ROW_W      = 10;
	localparam int COL_W      = 12;
	localparam int OFS_W      = 26;
	localparam int DIM_W      = 13;
	localparam int CTR_W      = 17;
	localparam int RAD_W      = 16;
	localparam int ANG_W      = 16;
	localparam int UH_W       = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam int ONE_Q16        = 65536;
	localparam int INV_TWO_PI_Q16 = 10430;

	localparam int CORDIC_STEPS = 16;
	localparam int CX_W         = 34;
	localparam int CZ_W         = 18;
	localparam int TRIG_W       = 18;
	localparam logic signed [CX_W-1:0] CORDIC_GAIN = CX_W'(652032874);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIG_WIDTH   = 3'd0,
		CFG_ORIG_HEIGHT  = 3'd1,
		CFG_UNWRAP_WIDTH = 3'd2,
		CFG_CENTRE_U     = 3'd3,
		CFG_CENTRE_V     = 3'd4,
		CFG_RADIUS_MIN   = 3'd5,
		CFG_RADIUS_MAX   = 3'd6,
		CFG_OFFSET_ANGLE = 3'd7
	} cfg_idx_t;

	// arctangent of 2^-k in 1/65536 turn
	function automatic logic signed [CZ_W-1:0] atan_turn(input int k);
		logic signed [CZ_W-1:0] a;
		case (k)
			0:       a = CZ_W'(8192);
			1:       a = CZ_W'(4836);
			2:       a = CZ_W'(2555);
			3:       a = CZ_W'(1297);
			4:       a = CZ_W'(651);
			5:       a = CZ_W'(326);
			6:       a = CZ_W'(163);
			7:       a = CZ_W'(81);
			8:       a = CZ_W'(41);
			9:       a = CZ_W'(20);
			10:      a = CZ_W'(10);
			11:      a = CZ_W'(5);
			12:      a = CZ_W'(3);
			13:      a = CZ_W'(1);
			14:      a = CZ_W'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

/* hw/rtl/puag_pix_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// puag_pix_if
// Panorama pixel coordinate channel.
// ----------------------------------------------------------------------------
interface puag_pix_if;
	logic                            valid;
	logic                            ready;
	logic [puag_pkg::ROW_W-1:0]      out_row;
	logic [puag_pkg::COL_W-1:0]      out_col;

	modport source(output valid, out_row, out_col, input ready);
	modport sink(input valid, out_row, out_col, output ready);
endinterface

/* hw/rtl/puag_addr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// puag_addr_if
// Source address result channel.
// ----------------------------------------------------------------------------
interface puag_addr_if;
	logic                            valid;
	logic                            ready;
	logic [puag_pkg::OFS_W-1:0]      source_offset;
	logic                            in_frame;
	logic                            geometry_ok;

	modport source(output valid, source_offset, in_frame, geometry_ok, input ready);
	modport sink(input valid, source_offset, in_frame, geometry_ok, output ready);
endinterface

/* hw/rtl/puag_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// puag_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface puag_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [puag_pkg::CFG_IDX_W-1:0]    index;
	logic [puag_pkg::CFG_DATA_W-1:0]   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* hw/rtl/puag_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// puag_div
// Pipelined restoring divider, one quotient bit per stage. The partial
// remainder starts at rem0 (below the divisor) and NW dividend bits are
// shifted in. Side data travels with each item.
// ----------------------------------------------------------------------------
module puag_div #(
	parameter int  NW     = 16,
	parameter type side_t = logic
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [puag_pkg::DIM_W-1:0]  divisor,
	input  logic [puag_pkg::DIM_W-1:0]  rem0,
	input  logic [NW-1:0]               num,
	input  side_t                       side_in,
	output logic                        out_valid,
	output logic [NW-1:0]               quot,
	output side_t                       side_out
);

	localparam int DW = puag_pkg::DIM_W;

	logic [NW-1:0]         vld_s;
	logic [DW-1:0]         rem_s [NW];
	logic [DW-1:0]         dvs_s [NW];
	logic [NW-1:0]         num_s [NW];
	logic [NW-1:0]         q_s   [NW];
	side_t                 side_s [NW];

	for (genvar k = 0; k < NW; k++) begin : g_step
		logic          vld_p;
		logic [DW-1:0] rem_p;
		logic [DW-1:0] dvs_p;
		logic [NW-1:0] num_p;
		logic [NW-1:0] q_p;
		side_t         side_p;
		logic [DW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign vld_p  = in_valid;
			assign rem_p  = rem0;
			assign dvs_p  = divisor;
			assign num_p  = num;
			assign q_p    = '0;
			assign side_p = side_in;
		end else begin : g_next
			assign vld_p  = vld_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign dvs_p  = dvs_s[k-1];
			assign num_p  = num_s[k-1];
			assign q_p    = q_s[k-1];
			assign side_p = side_s[k-1];
		end

		assign trial = {rem_p, num_p[NW-1]};
		assign ge    = trial >= {1'b0, dvs_p};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? DW'(trial - {1'b0, dvs_p}) : trial[DW-1:0];
				dvs_s[k]  <= dvs_p;
				num_s[k]  <= num_p << 1;
				q_s[k]    <= {q_p[NW-2:0], ge};
				side_s[k] <= side_p;
			end
		end
	end

	assign out_valid = vld_s[NW-1];
	assign quot      = q_s[NW-1];
	assign side_out  = side_s[NW-1];

endmodule

/* hw/rtl/puag_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// puag_cordic
// Pipelined rotation CORDIC, one iteration per stage, on a 16-bit turn
// angle. A last stage scales to Q16 and folds in the quadrant.
// ----------------------------------------------------------------------------
module puag_cordic #(
	parameter type side_t = logic
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic [puag_pkg::ANG_W-1:0]          theta,
	input  side_t                               side_in,
	output logic                                out_valid,
	output logic signed [puag_pkg::TRIG_W-1:0]  sin_q,
	output logic signed [puag_pkg::TRIG_W-1:0]  cos_q,
	output side_t                               side_out
);

	localparam int N  = puag_pkg::CORDIC_STEPS;
	localparam int XW = puag_pkg::CX_W;
	localparam int ZW = puag_pkg::CZ_W;
	localparam int TW = puag_pkg::TRIG_W;

	logic [N-1:0]          vld_s;
	logic signed [XW-1:0]  x_s [N];
	logic signed [XW-1:0]  y_s [N];
	logic signed [ZW-1:0]  z_s [N];
	logic [1:0]            quad_s [N];
	side_t                 side_s [N];

	for (genvar k = 0; k < N; k++) begin : g_iter
		logic                 vld_p;
		logic signed [XW-1:0] x_p;
		logic signed [XW-1:0] y_p;
		logic signed [ZW-1:0] z_p;
		logic [1:0]           quad_p;
		side_t                side_p;

		if (k == 0) begin : g_first
			assign vld_p  = in_valid;
			assign x_p    = puag_pkg::CORDIC_GAIN;
			assign y_p    = '0;
			assign z_p    = ZW'(theta[13:0]);
			assign quad_p = theta[15:14];
			assign side_p = side_in;
		end else begin : g_next
			assign vld_p  = vld_s[k-1];
			assign x_p    = x_s[k-1];
			assign y_p    = y_s[k-1];
			assign z_p    = z_s[k-1];
			assign quad_p = quad_s[k-1];
			assign side_p = side_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (z_p >= 0) begin
					x_s[k] <= x_p - (y_p >>> k);
					y_s[k] <= y_p + (x_p >>> k);
					z_s[k] <= z_p - puag_pkg::atan_turn(k);
				end else begin
					x_s[k] <= x_p + (y_p >>> k);
					y_s[k] <= y_p - (x_p >>> k);
					z_s[k] <= z_p + puag_pkg::atan_turn(k);
				end
				quad_s[k] <= quad_p;
				side_s[k] <= side_p;
			end
		end
	end

	logic signed [TW-1:0] xq;
	logic signed [TW-1:0] yq;

	assign xq = TW'(x_s[N-1] >>> 14);
	assign yq = TW'(y_s[N-1] >>> 14);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_s[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (quad_s[N-1])
				2'd0: begin
					sin_q <= yq;
					cos_q <= xq;
				end
				2'd1: begin
					sin_q <= xq;
					cos_q <= -yq;
				end
				2'd2: begin
					sin_q <= -yq;
					cos_q <= -xq;
				end
				default: begin
					sin_q <= -xq;
					cos_q <= yq;
				end
			endcase
			side_out <= side_s[N-1];
		end
	end

endmodule

/* hw/rtl/polar_unwrap_address_gen_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_unwrap_address_gen_core
// Maps a panorama pixel (row, column) to the byte offset of its source
// pixel in the circular camera frame, with frame and geometry flags.
//
//   channel  dir  payload                                  handshake
//   pixel    in   out_row, out_col                         valid/ready
//   addr     out  source_offset, in_frame, geometry_ok     valid/ready
//   cfg      in   index, data                              valid/ready
//
// One pixel per clock unless stalled. Stages: two setup stages, a 16-stage
// angle/radius divider, one radius/angle stage, a 17-stage CORDIC, three
// multiply stages, an 18-stage u divider and four address stages, the last
// being the output register. A stall on addr freezes every stage; nothing
// is dropped. arst_n clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module polar_unwrap_address_gen_core #(
	parameter int MAX_UNWRAP_WIDTH = 4096,
	parameter int MAX_ORIG_SIDE    = 4096,
	parameter int BYTES_PER_PIXEL  = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	puag_pix_if.sink           pixel,
	puag_addr_if.source        addr,
	puag_cfg_if.sink           cfg
);

	localparam int DW = puag_pkg::DIM_W;
	localparam int RW = puag_pkg::RAD_W;
	localparam int TW = puag_pkg::TRIG_W;
	localparam int HW = puag_pkg::UH_W;
	localparam int OW = puag_pkg::OFS_W;

	typedef struct packed {
		logic          inrange;
		logic          geo_ok;
		logic [DW-1:0] ow;
		logic [DW-1:0] oh;
		logic [DW-1:0] hdiv;
	} geo_t;

	typedef struct packed {
		geo_t          g;
		logic [RW-1:0] rad;
	} trig_side_t;

	typedef struct packed {
		logic          inrange;
		logic          geo_ok;
		logic [DW-1:0] ow;
		logic [DW-1:0] oh;
		logic          uneg;
		logic          ovf;
		logic [16:0]   xp;
	} u_side_t;

	// registers
	logic [DW-1:0]                  orig_width_q, orig_height_q, unwrap_width_q;
	logic [puag_pkg::CTR_W-1:0]     centre_u_q, centre_v_q;
	logic [RW-1:0]                  radius_min_q, radius_max_q;
	logic [puag_pkg::ANG_W-1:0]     offset_angle_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orig_width_q   <= DW'(640);
			orig_height_q  <= DW'(480);
			unwrap_width_q <= DW'(800);
			centre_u_q     <= 17'd32768;
			centre_v_q     <= 17'd32768;
			radius_min_q   <= 16'd6554;
			radius_max_q   <= 16'd26214;
			offset_angle_q <= '0;
		end else if (cfg.valid) begin
			case (puag_pkg::cfg_idx_t'(cfg.index))
				puag_pkg::CFG_ORIG_WIDTH:   orig_width_q   <= cfg.data[DW-1:0];
				puag_pkg::CFG_ORIG_HEIGHT:  orig_height_q  <= cfg.data[DW-1:0];
				puag_pkg::CFG_UNWRAP_WIDTH: unwrap_width_q <= cfg.data[DW-1:0];
				puag_pkg::CFG_CENTRE_U:     centre_u_q     <= cfg.data;
				puag_pkg::CFG_CENTRE_V:     centre_v_q     <= cfg.data;
				puag_pkg::CFG_RADIUS_MIN:   radius_min_q   <= cfg.data[RW-1:0];
				puag_pkg::CFG_RADIUS_MAX:   radius_max_q   <= cfg.data[RW-1:0];
				puag_pkg::CFG_OFFSET_ANGLE: offset_angle_q <= cfg.data[RW-1:0];
				default: ;
			endcase
		end
	end

	// global advance
	logic en;
	logic v1_s, v2_s, v4_s, v5_s, v6_s, v8_s, v9_s;
	logic vdiv_a, vcor, vdiv_u, v3_s, v7_s, v10_s;

	assign en          = !v10_s || addr.ready;
	assign pixel.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s  <= 1'b0;
			v2_s  <= 1'b0;
			v3_s  <= 1'b0;
			v4_s  <= 1'b0;
			v5_s  <= 1'b0;
			v6_s  <= 1'b0;
			v7_s  <= 1'b0;
			v8_s  <= 1'b0;
			v9_s  <= 1'b0;
			v10_s <= 1'b0;
		end else if (en) begin
			v1_s  <= pixel.valid;
			v2_s  <= v1_s;
			v3_s  <= vdiv_a;
			v4_s  <= vcor;
			v5_s  <= v4_s;
			v6_s  <= v5_s;
			v7_s  <= vdiv_u;
			v8_s  <= v7_s;
			v9_s  <= v8_s;
			v10_s <= v9_s;
		end
	end

	// stage 1: saturate sizes, panorama height, ring span
	logic [DW-1:0]       ow_c, oh_c, uw_c;
	logic [26:0]         uh_prod;
	logic [28:0]         span_prod;
	logic [puag_pkg::ROW_W-1:0] row_s1;
	logic [puag_pkg::COL_W-1:0] col_s1;
	logic [DW-1:0]       ow_s1, oh_s1, uw_s1;
	logic [HW-1:0]       uh_s1;
	logic [13:0]         span_s1;

	always_comb begin
		ow_c = (32'(orig_width_q) > MAX_ORIG_SIDE) ? DW'(MAX_ORIG_SIDE) : orig_width_q;
		oh_c = (32'(orig_height_q) > MAX_ORIG_SIDE) ? DW'(MAX_ORIG_SIDE) : orig_height_q;
		uw_c = (32'(unwrap_width_q) > MAX_UNWRAP_WIDTH) ? DW'(MAX_UNWRAP_WIDTH)
			: unwrap_width_q;
		uh_prod   = 27'(uw_c) * 27'(puag_pkg::INV_TWO_PI_Q16);
		span_prod = 29'(ow_c) * 29'(radius_max_q);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_s1  <= pixel.out_row;
			col_s1  <= pixel.out_col;
			ow_s1   <= ow_c;
			oh_s1   <= oh_c;
			uw_s1   <= uw_c;
			uh_s1   <= uh_prod[26:16];
			span_s1 <= span_prod[28:15];
		end
	end

	// stage 2: range check, ring index times radius span
	logic [HW-1:0] ring_i;
	logic          dneg_c;
	logic [RW-1:0] dmag_c;
	geo_t          geo_s2;
	logic          dneg_s2;
	logic [26:0]   rnum_s2;
	logic [DW-1:0] uw_s2;
	logic [puag_pkg::COL_W-1:0] col_s2;
	logic [HW-1:0] uh_s2;

	always_comb begin
		ring_i = uh_s1 - HW'(1) - HW'(row_s1);
		dneg_c = radius_max_q < radius_min_q;
		dmag_c = dneg_c ? radius_min_q - radius_max_q : radius_max_q - radius_min_q;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s2.inrange <= (uh_s1 != '0) && (HW'(row_s1) < uh_s1)
				&& (DW'(col_s1) < uw_s1);
			geo_s2.geo_ok  <= {1'b0, span_s1} <= 15'(oh_s1);
			geo_s2.ow      <= ow_s1;
			geo_s2.oh      <= oh_s1;
			geo_s2.hdiv    <= (oh_s1 == '0) ? DW'(1) : oh_s1;
			dneg_s2        <= dneg_c;
			rnum_s2        <= 27'(dmag_c) * 27'(ring_i);
			uw_s2          <= uw_s1;
			col_s2         <= col_s1;
			uh_s2          <= uh_s1;
		end
	end

	// angle and radius divisions
	logic [15:0] qt, qr;
	logic        dneg_d;
	geo_t        geo_d;

	puag_div #(.NW(16), .side_t(logic)) u_div_ang (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v2_s),
		.divisor   (uw_s2),
		.rem0      (DW'(col_s2)),
		.num       (16'd0),
		.side_in   (dneg_s2),
		.out_valid (),
		.quot      (qt),
		.side_out  (dneg_d)
	);

	puag_div #(.NW(16), .side_t(geo_t)) u_div_rad (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v2_s),
		.divisor   (DW'(uh_s2)),
		.rem0      (DW'(rnum_s2[26:16])),
		.num       (rnum_s2[15:0]),
		.side_in   (geo_s2),
		.out_valid (vdiv_a),
		.quot      (qr),
		.side_out  (geo_d)
	);

	// stage 3: radius and angle
	trig_side_t              tside_s3;
	logic [puag_pkg::ANG_W-1:0] theta_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			tside_s3.g   <= geo_d;
			tside_s3.rad <= dneg_d ? radius_min_q - qr : radius_min_q + qr;
			theta_s3     <= qt + offset_angle_q;
		end
	end

	logic signed [TW-1:0] sin_c, cos_c;
	trig_side_t           tside_c;

	puag_cordic #(.side_t(trig_side_t)) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v3_s),
		.theta     (theta_s3),
		.side_in   (tside_s3),
		.out_valid (vcor),
		.sin_q     (sin_c),
		.cos_q     (cos_c),
		.side_out  (tside_c)
	);

	// stage 4: width times radius, cos times radius
	logic [28:0]          m1_s4;
	logic signed [34:0]   cr_s4;
	logic signed [TW-1:0] sin_s4;
	geo_t                 geo_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s4  <= 29'(tside_c.g.ow) * 29'(tside_c.rad);
			cr_s4  <= 35'(cos_c) * 35'(signed'({1'b0, tside_c.rad}));
			sin_s4 <= sin_c;
			geo_s4 <= tside_c.g;
		end
	end

	// stage 5: sine term numerator, v coordinate
	logic [34:0]        crmag;
	logic signed [19:0] vt, v_c;
	logic signed [47:0] n_s5;
	logic [19:0]        wv_s5;
	geo_t               geo_s5;

	always_comb begin
		crmag = cr_s4[34] ? 35'(-cr_s4) : 35'(cr_s4);
		vt    = cr_s4[34] ? -signed'(20'(crmag[34:16])) : signed'(20'(crmag[34:16]));
		v_c   = 20'sd65536 - signed'({3'b0, centre_v_q}) + vt;
		if (v_c > 20'sd65536) begin
			v_c = 20'sd65536;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s5   <= 48'(sin_s4) * 48'(signed'({1'b0, m1_s4}));
			wv_s5  <= 20'(20'sd65536 - v_c);
			geo_s5 <= geo_s4;
		end
	end

	// stage 6: magnitude scaling, overflow test, x pixel
	logic [47:0] nmag;
	logic [31:0] dq;
	logic [32:0] xprod;
	u_side_t     uside_s6;
	logic [DW-1:0] hdiv_s6;
	logic [DW-1:0] rem0_s6;
	logic [17:0]   num_s6;

	always_comb begin
		nmag  = n_s5[47] ? 48'(-n_s5) : 48'(n_s5);
		dq    = nmag[47:16];
		xprod = 33'(wv_s5) * 33'(geo_s5.ow);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			uside_s6.inrange <= geo_s5.inrange;
			uside_s6.geo_ok  <= geo_s5.geo_ok;
			uside_s6.ow      <= geo_s5.ow;
			uside_s6.oh      <= geo_s5.oh;
			uside_s6.uneg    <= n_s5[47];
			uside_s6.ovf     <= dq[31:18] >= {1'b0, geo_s5.hdiv};
			uside_s6.xp      <= xprod[32:16];
			hdiv_s6          <= geo_s5.hdiv;
			rem0_s6          <= dq[30:18];
			num_s6           <= dq[17:0];
		end
	end

	logic [17:0] qu;
	u_side_t     uside_d;

	puag_div #(.NW(18), .side_t(u_side_t)) u_div_u (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v6_s),
		.divisor   (hdiv_s6),
		.rem0      (rem0_s6),
		.num       (num_s6),
		.side_in   (uside_s6),
		.out_valid (vdiv_u),
		.quot      (qu),
		.side_out  (uside_d)
	);

	// stage 7: u coordinate
	logic [18:0]        qmag;
	logic signed [20:0] u_c;
	logic [19:0]        wu_s7;
	u_side_t            uside_s7;

	always_comb begin
		qmag = uside_d.ovf ? 19'h40000 : 19'(qu);
		u_c  = signed'(21'(centre_u_q));
		if (uside_d.uneg) begin
			u_c = u_c - signed'(21'(qmag));
		end else begin
			u_c = u_c + signed'(21'(qmag));
		end
		if (u_c > 21'sd65536) begin
			u_c = 21'sd65536;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wu_s7    <= 20'(21'sd65536 - u_c);
			uside_s7 <= uside_d;
		end
	end

	// stage 8: y pixel and frame test
	logic [32:0]   yprod;
	logic [DW-1:0] yp_s8;
	logic [DW-1:0] xp_s8;
	logic [DW-1:0] ow_s8;
	logic          inside_s8;
	logic          geo_ok_s8;

	assign yprod = 33'(wu_s7) * 33'(uside_s7.oh);

	always_ff @(posedge clk) begin
		if (en) begin
			yp_s8     <= yprod[28:16];
			xp_s8     <= uside_s7.xp[DW-1:0];
			ow_s8     <= uside_s7.ow;
			inside_s8 <= uside_s7.inrange && (uside_s7.xp < 17'(uside_s7.ow))
				&& (yprod[32:16] < 17'(uside_s7.oh));
			geo_ok_s8 <= uside_s7.geo_ok;
		end
	end

	// stage 9: linear pixel index
	logic [OW-1:0] lin_s9;
	logic          inside_s9;
	logic          geo_ok_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			lin_s9    <= OW'(yp_s8) * OW'(ow_s8) + OW'(xp_s8);
			inside_s9 <= inside_s8;
			geo_ok_s9 <= geo_ok_s8;
		end
	end

	// stage 10: output register
	logic [OW-1:0] ofs_s10;
	logic          inside_s10;
	logic          geo_ok_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			ofs_s10    <= inside_s9 ? OW'(lin_s9 * OW'(BYTES_PER_PIXEL)) : '0;
			inside_s10 <= inside_s9;
			geo_ok_s10 <= geo_ok_s9;
		end
	end

	assign addr.valid         = v10_s;
	assign addr.source_offset = ofs_s10;
	assign addr.in_frame      = inside_s10;
	assign addr.geometry_ok   = geo_ok_s10;

endmodule
